// ===== src/lmts_pkg.sv =====
`timescale 1ns / 1ps

package lmts_pkg;

  // Store sizes. The font size is kept a power of two so that address
  // wrap is a plain truncation.
  localparam int MESSAGE_DEPTH = 64;
  localparam int FONT_BYTES    = 256;
  localparam int MSG_AW        = $clog2(MESSAGE_DEPTH);
  localparam int FONT_AW       = $clog2(FONT_BYTES);

  // Font layout and screen geometry.
  localparam int         SCREEN_ROWS    = 8;
  localparam int         ROW_AW         = $clog2(SCREEN_ROWS);
  localparam int         GLYPH_STRIDE   = 4;
  localparam logic [7:0] WIDTH_BYTE     = 8'd3;
  localparam int         LIT_ROWS       = 7;
  localparam logic [7:0] NEW_COLUMN_BIT = 8'h01;
  localparam logic [7:0] PASS_MAX       = 8'hFF;

  // Configuration port.
  localparam int   APB_AW               = 3;
  localparam logic REG_MESSAGE_LENGTH   = 1'b0;
  localparam logic REG_CHAR_CODE_OFFSET = 1'b1;

  typedef enum logic [1:0] {
    OP_REFRESH    = 2'd0,
    OP_SCROLL     = 2'd1,
    OP_MSG_WRITE  = 2'd2,
    OP_FONT_WRITE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MSG,
    S_WIDTH,
    S_COL
  } state_t;

  // Font byte address of byte idx of a glyph, wrapped to the font size.
  function automatic logic [FONT_AW-1:0] font_addr(logic [7:0] glyph, logic [7:0] idx);
    logic [10:0] sum;
    sum = 11'(glyph) * 11'(GLYPH_STRIDE) + 11'(idx);
    return sum[FONT_AW-1:0];
  endfunction

endpackage

// ===== src/lmts_ram.sv =====
`timescale 1ns / 1ps

module lmts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, read-before-write on a write, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/led_matrix_text_scroller.sv =====
`timescale 1ns / 1ps
// Refresh and load words give their result in the cycle after acceptance, one word per
// cycle while the output is not stalled. A scroll word that draws a column does one font
// RAM read; one that ends a character reads the message RAM, then the dependent font RAM.
// No word is taken while a scroll is in the engine or while a result waits unaccepted.
// Synchronous active-high reset clears the screen, counters and handshake state;
// the message and font RAMs are not cleared and hold garbage until written.

module led_matrix_text_scroller (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       op,
  input  logic [7:0]                       load_address,
  input  logic [7:0]                       load_data,
  // output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lmts_pkg::ROW_AW-1:0]      row_index,
  output logic [7:0]                       row_pixels,
  output logic [7:0]                       pass_count,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lmts_pkg::APB_AW-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  import lmts_pkg::*;

  state_t state, state_next;

  logic [7:0]        rows [SCREEN_ROWS];
  logic [7:0]        rows_next [SCREEN_ROWS];
  logic [ROW_AW-1:0] cur_row, cur_row_next;
  logic [MSG_AW-1:0] position, position_next;
  logic [7:0]        glyph, glyph_next;
  logic [7:0]        glyph_column, glyph_column_next;
  logic [7:0]        glyph_width, glyph_width_next;
  logic [7:0]        passes, passes_next;

  logic [6:0]        msg_length;
  logic [7:0]        char_code_offset;

  logic              msg_we;
  logic [MSG_AW-1:0] msg_addr;
  logic [7:0]        msg_rdata;
  logic              font_we;
  logic [FONT_AW-1:0] font_addr_sel;
  logic [7:0]        font_rdata;

  logic              in_fire;
  logic              emit;
  logic [MSG_AW:0]   position_inc;
  op_t               op_code;

  assign op_code = op_t'(op);
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign position_inc = {1'b0, position} + 1'b1;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_length       <= 7'd1;
      char_code_offset <= 8'd32;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MESSAGE_LENGTH:   msg_length       <= pwdata[6:0];
        REG_CHAR_CODE_OFFSET: char_code_offset <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MESSAGE_LENGTH:   prdata = 32'(msg_length);
      REG_CHAR_CODE_OFFSET: prdata = 32'(char_code_offset);
      default:              prdata = '0;
    endcase
  end

  // Message and font stores.
  lmts_ram #(.WIDTH(8), .DEPTH(MESSAGE_DEPTH)) u_msg_ram (
    .clk   (clk),
    .we    (msg_we),
    .addr  (msg_addr),
    .wdata (load_data),
    .rdata (msg_rdata)
  );

  lmts_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font_ram (
    .clk   (clk),
    .we    (font_we),
    .addr  (font_addr_sel),
    .wdata (load_data),
    .rdata (font_rdata)
  );

  // Next state of the scroll sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && op_code == OP_SCROLL) begin
          state_next = (glyph_column == glyph_width) ? S_MSG : S_COL;
        end
      end
      S_MSG:   state_next = S_WIDTH;
      S_WIDTH: state_next = S_IDLE;
      S_COL:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath: RAM addressing and read-modify-write of the scroll state.
  always_comb begin
    rows_next         = rows;
    cur_row_next      = cur_row;
    position_next     = position;
    glyph_next        = glyph;
    glyph_column_next = glyph_column;
    glyph_width_next  = glyph_width;
    passes_next       = passes;
    msg_we            = 1'b0;
    msg_addr          = MSG_AW'(load_address);
    font_we           = 1'b0;
    font_addr_sel     = FONT_AW'(load_address);
    emit              = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (op_code)
            OP_REFRESH: begin
              cur_row_next = cur_row + 1'b1;
              emit = 1'b1;
            end
            OP_SCROLL: begin
              for (int i = 0; i < SCREEN_ROWS; i++) begin
                rows_next[i] = {rows[i][6:0], 1'b0};
              end
              if (glyph_column == glyph_width) begin
                // Character done: advance the position and fetch the next code.
                if (32'(position_inc) >= 32'(msg_length) ||
                    32'(position_inc) >= MESSAGE_DEPTH) begin
                  position_next = '0;
                  if (passes != PASS_MAX) begin
                    passes_next = passes + 1'b1;
                  end
                end else begin
                  position_next = position_inc[MSG_AW-1:0];
                end
                msg_addr = position_next;
              end else begin
                font_addr_sel     = font_addr(glyph, glyph_column);
                glyph_column_next = glyph_column + 1'b1;
              end
            end
            OP_MSG_WRITE: begin
              msg_we = (32'(load_address) < MESSAGE_DEPTH);
              emit = 1'b1;
            end
            OP_FONT_WRITE: begin
              font_we = (32'(load_address) < FONT_BYTES);
              emit = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_MSG: begin
        glyph_next    = msg_rdata - char_code_offset;
        font_addr_sel = font_addr(glyph_next, WIDTH_BYTE);
      end
      S_WIDTH: begin
        glyph_width_next  = font_rdata;
        glyph_column_next = '0;
        emit = 1'b1;
      end
      S_COL: begin
        for (int i = 0; i < LIT_ROWS; i++) begin
          if (font_rdata[i]) begin
            rows_next[i+1] = rows[i+1] | NEW_COLUMN_BIT;
          end
        end
        emit = 1'b1;
      end
      default: ;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur_row      <= '0;
      position     <= '0;
      glyph        <= '0;
      glyph_column <= '0;
      glyph_width  <= '0;
      passes       <= '0;
      for (int i = 0; i < SCREEN_ROWS; i++) begin
        rows[i] <= '0;
      end
    end else begin
      state        <= state_next;
      cur_row      <= cur_row_next;
      position     <= position_next;
      glyph        <= glyph_next;
      glyph_column <= glyph_column_next;
      glyph_width  <= glyph_width_next;
      passes       <= passes_next;
      rows         <= rows_next;
    end
  end

  // Output register; the result word is captured as the item finishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row_index  <= cur_row_next;
      row_pixels <= rows_next[cur_row_next];
      pass_count <= passes_next;
    end
  end

endmodule

// ===== src/lmts_checker.sv =====
`timescale 1ns / 1ps

module lmts_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lmts_pkg::ROW_AW-1:0] row_index,
  input logic [7:0]                  row_pixels,
  input logic [7:0]                  pass_count
);

  import lmts_pkg::*;

  // A result that is held back keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_index) &&
                                $stable(row_pixels) && $stable(pass_count))
    else $error("result word changed while stalled");

  // Nothing is taken in while a result waits.
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // A taken scroll word puts the engine in a busy state that holds off the input.
  a_scroll_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_SCROLL |=> !in_ready)
    else $error("input ready during scroll");

  // Refresh and load words produce their result in the next cycle.
  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op != OP_SCROLL |=> out_valid)
    else $error("missing result after refresh or load");

  // Reset leaves the output channel empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind led_matrix_text_scroller lmts_checker u_lmts_checker (.*);

// ===== verif/scroller_checker.sv =====
`timescale 1ns / 1ps

module scroller_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic [7:0]                  load_address,
  input  logic [7:0]                  load_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [lmts_pkg::ROW_AW-1:0] row_index,
  input  logic [7:0]                  row_pixels,
  input  logic [7:0]                  pass_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [lmts_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          mismatch_count,
  output int                          rows_outstanding
);

  import lmts_pkg::*;

  // What one result word shows: the active row, its pixels and the pass count.
  typedef struct packed {
    logic [ROW_AW-1:0] row;
    logic [7:0]        pixels;
    logic [7:0]        passes;
  } row_view_t;

  // Our own copy of the display state and the two registers.
  logic [7:0]        screen [SCREEN_ROWS];
  logic [ROW_AW-1:0] shown_row;
  logic [7:0]        msg_mem [MESSAGE_DEPTH];
  logic [7:0]        font_mem [FONT_BYTES];
  int unsigned       msg_pos;
  logic [7:0]        glyph;
  logic [7:0]        glyph_col;
  logic [7:0]        glyph_width;
  logic [7:0]        passes;
  logic [6:0]        msg_len;
  logic [7:0]        code_offset;

  row_view_t expected_rows [$];
  int        errors = 0;

  assign mismatch_count = errors;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  // Byte b of glyph g in the font store, wrapped to the store size.
  function automatic int unsigned font_index(input logic [7:0] g, input logic [7:0] b);
    return (int'(g) * GLYPH_STRIDE + int'(b)) % FONT_BYTES;
  endfunction

  // One scroll step: shift every row left, then either move on to the next
  // character (leaving a blank column) or draw the next glyph column.
  task automatic scroll_screen();
    logic [7:0]  column_bits;
    int unsigned next_pos;
    for (int r = 0; r < SCREEN_ROWS; r++) begin
      screen[r] = screen[r] << 1;
    end
    if (glyph_col == glyph_width) begin
      next_pos = msg_pos + 1;
      if (next_pos >= msg_len || next_pos >= MESSAGE_DEPTH) begin
        next_pos = 0;
        if (passes != PASS_MAX) begin
          passes = passes + 8'd1;
        end
      end
      msg_pos     = next_pos;
      glyph       = msg_mem[msg_pos] - code_offset;
      glyph_width = font_mem[font_index(glyph, WIDTH_BYTE)];
      glyph_col   = 8'd0;
    end else begin
      column_bits = font_mem[font_index(glyph, glyph_col)];
      glyph_col   = glyph_col + 8'd1;
      for (int r = 0; r < LIT_ROWS; r++) begin
        if (column_bits[r]) begin
          screen[r+1] = screen[r+1] | NEW_COLUMN_BIT;
        end
      end
    end
  endtask

  // Applies one accepted word and returns the row view that it produces.
  task automatic apply_word(input op_t code, input logic [7:0] addr, input logic [7:0] data,
                            output row_view_t view);
    case (code)
      OP_REFRESH: begin
        shown_row = shown_row + 1'b1;
      end
      OP_SCROLL: begin
        scroll_screen();
      end
      OP_MSG_WRITE: begin
        if (int'(addr) < MESSAGE_DEPTH) begin
          msg_mem[int'(addr)] = data;
        end
      end
      default: begin
        if (int'(addr) < FONT_BYTES) begin
          font_mem[int'(addr)] = data;
        end
      end
    endcase
    view.row    = shown_row;
    view.pixels = screen[shown_row];
    view.passes = passes;
  endtask

  // Watch the register port and both channels at every edge. Results are
  // retired before a new word is predicted, since a result always belongs
  // to an earlier word.
  always @(posedge clk) begin : watch
    row_view_t got;
    row_view_t want;
    if (rst) begin
      for (int r = 0; r < SCREEN_ROWS; r++) begin
        screen[r] = 8'd0;
      end
      shown_row   = '0;
      msg_pos     = 0;
      glyph       = 8'd0;
      glyph_col   = 8'd0;
      glyph_width = 8'd0;
      passes      = 8'd0;
      msg_len     = 7'd1;
      code_offset = 8'd32;
      expected_rows.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[APB_AW-1:2] == REG_MESSAGE_LENGTH) begin
          msg_len = pwdata[6:0];
        end else if (paddr[APB_AW-1:2] == REG_CHAR_CODE_OFFSET) begin
          code_offset = pwdata[7:0];
        end
      end
      if (out_valid && out_ready) begin
        got = '{row_index, row_pixels, pass_count};
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected (row %0d pixels %h)",
                                    got.row, got.pixels));
        end else begin
          want = expected_rows.pop_front();
          if (got.row !== want.row) begin
            report_mismatch($sformatf("row_index %0d, expected %0d", got.row, want.row));
          end
          if (got.pixels !== want.pixels) begin
            report_mismatch($sformatf("row_pixels %h, expected %h (row %0d)",
                                      got.pixels, want.pixels, want.row));
          end
          if (got.passes !== want.passes) begin
            report_mismatch($sformatf("pass_count %0d, expected %0d",
                                      got.passes, want.passes));
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_word(op_t'(op), load_address, load_data, want);
        expected_rows.push_back(want);
      end
    end
    rows_outstanding = expected_rows.size();
  end

endmodule

// ===== verif/led_matrix_text_scroller_tb.sv =====
`timescale 1ns / 1ps

module led_matrix_text_scroller_tb;

  import lmts_pkg::*;

  localparam int RANDOM_WORDS    = 2000;
  localparam int PHASES          = 6;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           op;
  logic [7:0]           load_address;
  logic [7:0]           load_data;
  logic                 out_valid;
  logic                 out_ready;
  logic [ROW_AW-1:0]    row_index;
  logic [7:0]           row_pixels;
  logic [7:0]           pass_count;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  int                   mismatch_count;
  int                   rows_outstanding;

  // Idle switches for each side, and the request for one long receiver stall.
  bit                   tx_idle_en;
  bit                   rx_idle_en;
  bit                   hold_off_req;

  logic [6:0]           phase_len [PHASES];
  logic [7:0]           phase_ofs [PHASES];

  led_matrix_text_scroller u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .load_address (load_address),
    .load_data    (load_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .row_index    (row_index),
    .row_pixels   (row_pixels),
    .pass_count   (pass_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  scroller_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .op               (op),
    .load_address     (load_address),
    .load_data        (load_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .row_index        (row_index),
    .row_pixels       (row_pixels),
    .pass_count       (pass_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_count   (mismatch_count),
    .rows_outstanding (rows_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result receiver: short random stalls, plus one long stall on request
  // so that the block fills up and holds off its input.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one word and returns at the edge where it is taken. Valid is
  // only lowered when an idle burst goes in front of the word.
  task automatic send_word(input op_t code, input logic [7:0] addr, input logic [7:0] data);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= code;
    load_address <= addr;
    load_data    <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stops offering words, waits for every expected result and lets the engine settle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (rows_outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Character widths: mostly narrow, some wider than the four stored bytes,
  // a few zero and a few very wide.
  function automatic logic [7:0] pick_width();
    int unsigned pick;
    pick = $urandom_range(0, 63);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'($urandom_range(13, 255));
    if (pick < 8) return 8'($urandom_range(6, 12));
    return 8'($urandom_range(1, 5));
  endfunction

  function automatic logic [7:0] font_value(input logic [7:0] addr);
    if (addr[1:0] == WIDTH_BYTE[1:0]) return pick_width();
    return 8'($urandom);
  endfunction

  // One random word: mostly scroll and refresh, with loads that keep
  // reshaping the message and the font, some of them out of range.
  task automatic send_random_word();
    int unsigned pick;
    logic [7:0]  addr;
    pick = $urandom_range(0, 99);
    addr = 8'($urandom);
    if (pick < 45) begin
      send_word(OP_SCROLL, addr, 8'($urandom));
    end else if (pick < 80) begin
      send_word(OP_REFRESH, addr, 8'($urandom));
    end else if (pick < 90) begin
      if ($urandom_range(0, 3) != 0) begin
        addr = 8'($urandom_range(0, MESSAGE_DEPTH - 1));
      end
      send_word(OP_MSG_WRITE, addr, 8'($urandom));
    end else begin
      send_word(OP_FONT_WRITE, addr, font_value(addr));
    end
  endtask

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    op           <= OP_REFRESH;
    load_address <= 8'd0;
    load_data    <= 8'd0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= 32'd0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    hold_off_req = 1'b0;
    phase_len = '{7'd64, 7'd1, 7'd0, 7'd127, 7'($urandom_range(2, 63)), 7'd3};
    phase_ofs = '{8'd32, 8'd0, 8'd255, 8'($urandom), 8'd32, 8'($urandom)};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Two-character message with the usual code offset for the opening part.
    write_reg(REG_MESSAGE_LENGTH, 32'd2);
    write_reg(REG_CHAR_CODE_OFFSET, 32'd32);

    // Fill both stores completely so that no scroll can read an empty entry.
    for (int a = 0; a < MESSAGE_DEPTH; a++) begin
      send_word(OP_MSG_WRITE, 8'(a), 8'($urandom));
    end
    for (int a = 0; a < FONT_BYTES; a++) begin
      send_word(OP_FONT_WRITE, 8'(a), font_value(8'(a)));
    end

    // Directed part. The first scroll skips message character 0 and picks
    // up character 1, which maps to the last glyph; its width of six makes
    // the column reads run past the end of the font store and wrap to
    // byte 0. Loads beyond the message store must be dropped.
    send_word(OP_MSG_WRITE, 8'd1, 8'd95);
    send_word(OP_FONT_WRITE, 8'd255, 8'd6);
    send_word(OP_FONT_WRITE, 8'd252, 8'h55);
    send_word(OP_FONT_WRITE, 8'd253, 8'hAA);
    send_word(OP_FONT_WRITE, 8'd0, 8'hFF);
    send_word(OP_FONT_WRITE, 8'd1, 8'h00);
    send_word(OP_MSG_WRITE, 8'd64, 8'hFF);
    send_word(OP_MSG_WRITE, 8'd255, 8'h00);
    for (int s = 0; s < 8; s++) begin
      send_word(OP_SCROLL, 8'($urandom), 8'($urandom));
      send_word(OP_REFRESH, 8'($urandom), 8'($urandom));
    end

    // Random part, in phases with different register settings.
    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      write_reg(REG_MESSAGE_LENGTH, {25'd0, phase_len[p]});
      write_reg(REG_CHAR_CODE_OFFSET, {24'd0, phase_ofs[p]});
      for (int w = 0; w < RANDOM_WORDS / PHASES; w++) begin
        if (w % 100 == 0) begin
          tx_idle_en = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
          rx_idle_en = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        if (p == 1 && w == 50) begin
          hold_off_req = 1'b1;
        end
        send_random_word();
      end
    end

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
